>>> hw/rtl/circular_double_ended_queue_macros.svh
// assertion macros used by the deque rtl
// no dependencies; every user must have clk_i and rst_ni in scope
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// property must hold at every clock edge out of reset
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define CDQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hw/rtl/cdq_pkg.sv
// shared types, constants and index helpers for the circular deque
// no dependencies
package cdq_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CapW  = 5;
  localparam int WordW = 32;

  typedef enum logic [1:0] {
    ActPushFront = 2'd0,
    ActPushRear  = 2'd1,
    ActPopFront  = 2'd2,
    ActPopRear   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // one access to the entry store
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IdxW-1:0]  addr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

  // next slot, wrapping at the capacity
  function automatic logic [IdxW-1:0] wrap_up(logic [IdxW-1:0] idx, logic [CapW-1:0] cap);
    logic [CapW-1:0] nxt;
    nxt = CapW'(idx) + CapW'(1);
    return (nxt >= cap) ? '0 : nxt[IdxW-1:0];
  endfunction

  // previous slot, wrapping at the capacity
  function automatic logic [IdxW-1:0] wrap_down(logic [IdxW-1:0] idx, logic [CapW-1:0] cap);
    logic [CapW-1:0] prv;
    prv = cap - CapW'(1);
    return (idx == '0) ? prv[IdxW-1:0] : idx - IdxW'(1);
  endfunction

  // saturate a written capacity into 1..Depth
  function automatic logic [CapW-1:0] sat_cap(logic [CapW-1:0] raw);
    logic [CapW-1:0] c;
    c = raw;
    if (c == '0) begin
      c = CapW'(1);
    end
    if (c > CapW'(Depth)) begin
      c = CapW'(Depth);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cdq_ram.sv
// single-port synchronous word store, registered read data
// no dependencies
module cdq_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

>>> hw/rtl/cdq_ctrl.sv
// head/tail index control and result register for the circular deque
// depends on cdq_pkg and circular_double_ended_queue_macros.svh
`include "circular_double_ended_queue_macros.svh"

module cdq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   action_i,
  input  logic [cdq_pkg::WordW-1:0]    value_i,
  input  logic [cdq_pkg::CapW-1:0]     cap_i,
  input  logic                         clear_i,
  input  logic [cdq_pkg::WordW-1:0]    rdata_i,
  output cdq_pkg::mem_req_t            mem_req_o,
  output logic                         done_o,
  output logic [cdq_pkg::WordW-1:0]    popped_value_o,
  output logic [1:0]                   status_o
);

  logic [cdq_pkg::IdxW-1:0] head_q, head_d;
  logic [cdq_pkg::IdxW-1:0] tail_q, tail_d;
  logic                     ne_q, ne_d;
  logic                     done_q;
  logic                     pop_ok_q, pop_ok_d;
  cdq_pkg::status_e         status_q, status_d;
  cdq_pkg::action_e         act;
  logic                     full;

  assign act  = cdq_pkg::action_e'(action_i);
  assign full = ne_q && (cdq_pkg::wrap_up(tail_q, cap_i) == head_q);

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    ne_d            = ne_q;
    status_d        = cdq_pkg::StOk;
    pop_ok_d        = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = '0;
    mem_req_o.wdata = value_i;
    if (clear_i) begin
      head_d = '0;
      tail_d = '0;
      ne_d   = 1'b0;
    end else if (accept_i) begin
      case (act)
        cdq_pkg::ActPushFront, cdq_pkg::ActPushRear: begin
          if (full) begin
            status_d = cdq_pkg::StFull;
          end else if (!ne_q) begin
            // first word always lands in slot zero
            head_d       = '0;
            tail_d       = '0;
            ne_d         = 1'b1;
            mem_req_o.we = 1'b1;
          end else if (act == cdq_pkg::ActPushFront) begin
            head_d         = cdq_pkg::wrap_down(head_q, cap_i);
            mem_req_o.we   = 1'b1;
            mem_req_o.addr = head_d;
          end else begin
            tail_d         = cdq_pkg::wrap_up(tail_q, cap_i);
            mem_req_o.we   = 1'b1;
            mem_req_o.addr = tail_d;
          end
        end
        cdq_pkg::ActPopFront, cdq_pkg::ActPopRear: begin
          if (!ne_q) begin
            status_d = cdq_pkg::StEmpty;
          end else begin
            pop_ok_d       = 1'b1;
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = (act == cdq_pkg::ActPopFront) ? head_q : tail_q;
            if (head_q == tail_q) begin
              // last word leaves, back to the empty state
              head_d = '0;
              tail_d = '0;
              ne_d   = 1'b0;
            end else if (act == cdq_pkg::ActPopFront) begin
              head_d = cdq_pkg::wrap_up(head_q, cap_i);
            end else begin
              tail_d = cdq_pkg::wrap_down(tail_q, cap_i);
            end
          end
        end
        default: begin
          status_d = cdq_pkg::StOk;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      ne_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      ne_q   <= ne_d;
      done_q <= accept_i && !clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_ok_q <= pop_ok_d;
    status_q <= status_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? rdata_i : '0;

  `CDQ_ASSERT(a_empty_idx_zero, !ne_q |-> (head_q == '0 && tail_q == '0), "empty deque with live index")
  `CDQ_ASSERT(a_idx_in_cap, ne_q |-> (cdq_pkg::CapW'(head_q) < cap_i && cdq_pkg::CapW'(tail_q) < cap_i), "index beyond capacity")
  `CDQ_ASSERT(a_result_follows, (accept_i && !clear_i) |=> done_q, "accepted word gave no result")
  `CDQ_ASSERT_NEVER(a_pop_ok_value, done_q && pop_ok_q && status_q != cdq_pkg::StOk, "pop data with failing status")

endmodule

>>> hw/rtl/circular_double_ended_queue.sv
// circular deque: result strobed on done_o the cycle after start is taken (no result if a capacity write meets it)
// throughput 1 word per cycle; busy stays low, each access touches one store entry
// reset: deque empty, both indices 0, capacity 16; store content undefined until written
// results cannot be stalled by the receiver; capacity writes empty the deque
// depends on cdq_pkg, cdq_ctrl and cdq_ram
module circular_double_ended_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  // result channel
  output logic        done_o,
  output logic [31:0] popped_value_o,
  output logic [1:0]  status_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [cdq_pkg::CapW-1:0] cap_q;
  logic                     cfg_wr;
  logic                     cap_hit;
  logic                     accept;
  cdq_pkg::mem_req_t        mem_req;
  logic [cdq_pkg::WordW-1:0] rdata;

  // register decode: capacity is the only register, hit at byte addresses 0 to 3 (paddr[2] low); reads return it always
  assign pready  = 1'b1;
  assign cap_hit = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && cap_hit;
  assign prdata  = {{(32 - cdq_pkg::CapW){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cdq_pkg::CapW'(cdq_pkg::Depth);
    end else if (cfg_wr) begin
      cap_q <= cdq_pkg::sat_cap(pwdata[cdq_pkg::CapW-1:0]);
    end
  end

  // every word is settled with busy held low: indices in flops, one store access
  // a pop reads the entry at accept and the registered data meets done_o
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cdq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action_i),
    .value_i        (value_i),
    .cap_i          (cap_q),
    .clear_i        (cfg_wr),
    .rdata_i        (rdata),
    .mem_req_o      (mem_req),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

  // entry store; a pop at the same end right after a push reads the word that push wrote
  cdq_ram #(
    .Depth (cdq_pkg::Depth),
    .Width (cdq_pkg::WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

endmodule
